// ===== sv/lobm_pkg.sv =====
// ============================================================================
// lobm_pkg
// Shared types and codes for the price-time priority order matcher.
// ============================================================================
package lobm_pkg;

  localparam int unsigned DefaultDepth = 16;

  // request kinds
  localparam logic [1:0] ModeNew    = 2'd0;
  localparam logic [1:0] ModeCancel = 2'd1;
  localparam logic [1:0] ModeModify = 2'd2;

  // time in force
  localparam logic [1:0] TifGtc = 2'd0;
  localparam logic [1:0] TifIoc = 2'd1;
  localparam logic [1:0] TifFok = 2'd2;

  // final status codes
  localparam logic [2:0] StSuccess  = 3'd0;
  localparam logic [2:0] StPartial  = 3'd1;
  localparam logic [2:0] StCantFill = 3'd2;
  localparam logic [2:0] StBad      = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // one resting order
  typedef struct packed {
    logic        used;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] amount;
  } entry_t;

  // command broadcast from the sequencer to every cell of one book
  typedef struct packed {
    logic        del;      // remove the entry at del_pos, shift up
    logic [5:0]  del_pos;
    logic        ins;      // insert ins_entry at its sorted place
    entry_t      ins_entry;
    logic        set_amt;  // overwrite amount at amt_pos
    logic [5:0]  amt_pos;
    logic [31:0] amt_val;
  } book_cmd_t;

endpackage

// ===== sv/lobm_cell.sv =====
// ============================================================================
// lobm_cell
// One slot of a sorted book. Takes its neighbors' entries and shifts on
// insert or delete; also flags whether the incoming price sorts after it.
// ============================================================================
module lobm_cell #(
  parameter int unsigned POS = 0,
  parameter bit          IS_ASK = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lobm_pkg::book_cmd_t cmd,
  input  lobm_pkg::entry_t    prev_entry,  // entry of cell above
  input  lobm_pkg::entry_t    next_entry,  // entry of cell below
  input  logic                prev_before, // new entry goes below cell above
  output logic                ins_below,   // new entry goes below this cell
  output lobm_pkg::entry_t    entry
);

  lobm_pkg::entry_t entry_r, entry_nxt;

  // new order sorts after this entry at equal or better price
  always_comb begin
    if (IS_ASK) ins_below = entry_r.used && (entry_r.price <= cmd.ins_entry.price);
    else        ins_below = entry_r.used && (entry_r.price >= cmd.ins_entry.price);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.del && (6'(POS) >= cmd.del_pos)) begin
      entry_nxt = next_entry;
    end else if (cmd.ins) begin
      if (!ins_below) begin
        entry_nxt = prev_before ? cmd.ins_entry : prev_entry;
        if (!entry_r.used && !prev_before && !prev_entry.used) entry_nxt = entry_r;
      end
    end else if (cmd.set_amt && (cmd.amt_pos == 6'(POS))) begin
      entry_nxt.amount = cmd.amt_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.used <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

// ===== sv/lobm_book.sv =====
// ============================================================================
// lobm_book
// One side of the book: a chain of cells, best price at cell 0.
// ============================================================================
module lobm_book #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::DefaultDepth,
  parameter bit          IS_ASK = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lobm_pkg::book_cmd_t cmd,
  output lobm_pkg::entry_t    entries [BOOK_DEPTH]
);

  lobm_pkg::entry_t empty_e;
  logic             bef [BOOK_DEPTH];

  assign empty_e = '0;

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    lobm_pkg::entry_t pe, ne;
    logic             pb;
    // nothing sits above cell 0, so a new entry may always land there
    if (g == 0) begin : g_top
      assign pe = empty_e;
      assign pb = 1'b1;
    end else begin : g_mid
      assign pe = entries[g-1];
      assign pb = bef[g-1];
    end
    if (g == BOOK_DEPTH - 1) begin : g_bot
      assign ne = empty_e;
    end else begin : g_nb
      assign ne = entries[g+1];
    end
    lobm_cell #(.POS(g), .IS_ASK(IS_ASK)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .prev_entry(pe), .next_entry(ne), .prev_before(pb),
      .ins_below(bef[g]), .entry(entries[g])
    );
  end

endmodule

// ===== sv/limit_order_book_matcher_top.sv =====
// ============================================================================
// limit_order_book_matcher_top
// Price-time priority matcher over a bid and an ask chain of cells.
// ============================================================================
// Usage:
//   in_* carries one request (new, cancel, modify). out_* returns zero or more
//   trade items (kind 0) followed by one final status item (tlast high).
//   One request is worked on at a time; in_tready is high only when idle.
//   A limit order that trades nothing goes through decode, match, rest and
//   final before its status item is valid; with the receiver ready the next
//   request is accepted once that status item is taken.
//   A market order first walks up the opposite book to find its worst used
//   entry, a FOK order first makes a dry run over the opposite entries, and
//   each trade is emitted, then the book is updated at cell 0.
//   Cancel and modify scan one cell a cycle over bids then asks, then update
//   the book and load the status.
//   The trade loop sets the rate. Each output item sits in an output
//   register until taken; while out_tready is low the sequencer waits.
//   Reset empties both books, clears the id counter and drops any pending
//   item.
// ============================================================================
module limit_order_book_matcher_top #(
  parameter int unsigned BOOK_DEPTH = lobm_pkg::DefaultDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0] side[2] limit_price[34:3] amount[66:35] order_kind[67]
  // validity[69:68] target_id[101:70]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // buyer_id[31:0] seller_id[63:32] fill_price[95:64] fill_amount[127:96]
  // status[130:128] assigned_id[162:131]
  output logic [167:0] out_tdata,
  output logic         out_tuser,   // kind
  output logic         out_tlast    // last
);

  localparam int unsigned IW = $clog2(BOOK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FOK, S_MATCH, S_UPD, S_REST, S_SCAN, S_EDIT, S_FIN, S_WAIT
  } state_t;

  state_t state_r;
  logic [1:0]  mode_r, tif_r;
  logic        side_r;
  logic [31:0] price_r, qty_r, remain_r, target_r, cnt_id_r, id_r;
  logic [IW:0] idx_r;
  logic        scan_side_r;
  logic [2:0]  st_r;
  logic [31:0] asg_r;
  logic        ov_r, olast_r, okind_r;
  logic [31:0] ob_r, os_r, op_r, oa_r;
  logic [2:0]  ost_r;
  logic [31:0] oasg_r;
  logic        traded_r;
  logic        market_r;

  lobm_pkg::book_cmd_t cmd_b, cmd_a;
  lobm_pkg::entry_t    bid_e [BOOK_DEPTH];
  lobm_pkg::entry_t    ask_e [BOOK_DEPTH];

  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .IS_ASK(1'b0)) u_bid (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_b), .entries(bid_e));
  lobm_book #(.BOOK_DEPTH(BOOK_DEPTH), .IS_ASK(1'b1)) u_ask (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_a), .entries(ask_e));

  // opposite-side view and the scanned cell
  lobm_pkg::entry_t top_e, cur_e, scan_e, last_e;
  logic             crosses, own_full;
  logic [31:0]      fill;

  always_comb begin
    top_e    = side_r ? bid_e[0] : ask_e[0];
    cur_e    = side_r ? bid_e[idx_r[IW-1:0]] : ask_e[idx_r[IW-1:0]];
    scan_e   = scan_side_r ? ask_e[idx_r[IW-1:0]] : bid_e[idx_r[IW-1:0]];
    last_e   = side_r ? bid_e[idx_r[IW-1:0]] : ask_e[idx_r[IW-1:0]];
    own_full = side_r ? ask_e[BOOK_DEPTH-1].used : bid_e[BOOK_DEPTH-1].used;
    crosses  = top_e.used &&
               (side_r ? (price_r <= top_e.price) : (price_r >= top_e.price));
    fill     = (top_e.amount < remain_r) ? top_e.amount : remain_r;
  end

  logic fok_cross;
  assign fok_cross = cur_e.used &&
                     (side_r ? (price_r <= cur_e.price) : (price_r >= cur_e.price));

  logic [103:0] d;
  assign d = in_tdata;
  assign in_tready = (state_r == S_IDLE);

  // output register valid: set on a load, cleared when taken
  logic out_free, out_load, ov_nxt;
  assign out_free = !ov_r || out_tready;
  assign out_load = out_free &&
                    ((state_r == S_FIN) ||
                     (state_r == S_MATCH && remain_r != 32'd0 && crosses));
  assign ov_nxt   = out_load || (ov_r && !out_tready);

  // book commands, decided from the current state
  always_comb begin
    lobm_pkg::book_cmd_t c;
    c = '0;
    cmd_b = '0;
    cmd_a = '0;
    unique case (state_r)
      S_UPD: begin
        if (traded_r) begin
          if (top_e.amount == fill) begin
            c.del = 1'b1;
          end else begin
            c.set_amt = 1'b1;
            c.amt_val = top_e.amount - fill;
          end
        end
        if (side_r) cmd_b = c; else cmd_a = c;
      end
      S_REST: begin
        c.ins_entry = '{used: 1'b1, id: id_r, price: price_r, amount: remain_r};
        c.ins = (remain_r != 32'd0) && !own_full && (tif_r == lobm_pkg::TifGtc);
        if (side_r) cmd_a = c; else cmd_b = c;
      end
      S_EDIT: begin
        c.del_pos = 6'(idx_r);
        c.amt_pos = 6'(idx_r);
        c.amt_val = qty_r;
        if (st_r == lobm_pkg::StSuccess) begin
          c.del     = (mode_r == lobm_pkg::ModeCancel);
          c.set_amt = (mode_r == lobm_pkg::ModeModify);
        end
        if (scan_side_r) cmd_a = c; else cmd_b = c;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_id_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r      <= d[1:0];
            side_r      <= d[2];
            price_r     <= d[34:3];
            qty_r       <= d[66:35];
            remain_r    <= d[66:35];
            tif_r       <= d[67] ? lobm_pkg::TifIoc : d[69:68];
            target_r    <= d[101:70];
            idx_r       <= '0;
            scan_side_r <= 1'b0;
            asg_r       <= '0;
            traded_r    <= 1'b0;
            if (d[1:0] == lobm_pkg::ModeNew) begin
              cnt_id_r <= cnt_id_r + 32'd1;
              id_r     <= cnt_id_r + 32'd1;
              // market: locate worst opposite entry below
              if (d[67]) begin
                idx_r <= (IW+1)'(BOOK_DEPTH - 1);
              end
              state_r <= S_DECODE;
            end else if (d[1:0] == lobm_pkg::ModeCancel ||
                         d[1:0] == lobm_pkg::ModeModify) begin
              state_r <= S_SCAN;
            end else begin
              st_r    <= lobm_pkg::StBad;
              state_r <= S_FIN;
            end
          end
        end
        S_DECODE: begin
          // market order walks up to the last used opposite entry
          if (market_r && idx_r != '0 && !last_e.used) begin
            idx_r <= idx_r - 1'b1;
          end else if (market_r && !last_e.used) begin
            st_r    <= lobm_pkg::StCantFill;
            state_r <= S_FIN;
          end else begin
            if (market_r) price_r <= last_e.price;
            if ((market_r ? last_e.price : price_r) == 32'd0 || qty_r == 32'd0 ||
                tif_r > lobm_pkg::TifFok) begin
              st_r    <= lobm_pkg::StBad;
              state_r <= S_FIN;
            end else begin
              idx_r   <= '0;
              state_r <= (tif_r == lobm_pkg::TifFok) ? S_FOK : S_MATCH;
            end
          end
        end
        S_FOK: begin
          // dry run, one resting entry a cycle
          if (remain_r != 32'd0 && fok_cross && idx_r != (IW+1)'(BOOK_DEPTH)) begin
            remain_r <= (cur_e.amount < remain_r) ? remain_r - cur_e.amount : 32'd0;
            if (idx_r == (IW+1)'(BOOK_DEPTH - 1)) idx_r <= (IW+1)'(BOOK_DEPTH);
            else idx_r <= idx_r + 1'b1;
          end else if (remain_r != 32'd0) begin
            st_r    <= lobm_pkg::StCantFill;
            state_r <= S_FIN;
          end else begin
            remain_r <= qty_r;
            state_r  <= S_MATCH;
          end
        end
        S_MATCH: begin
          traded_r <= 1'b0;
          if (out_free) begin
            if (remain_r != 32'd0 && crosses) begin
              okind_r  <= 1'b0;
              olast_r  <= 1'b0;
              ob_r     <= side_r ? top_e.id : id_r;
              os_r     <= side_r ? id_r : top_e.id;
              op_r     <= top_e.price;
              oa_r     <= fill;
              ost_r    <= '0;
              oasg_r   <= '0;
              traded_r <= 1'b1;
              state_r  <= S_UPD;
            end else begin
              state_r <= S_REST;
            end
          end
        end
        S_UPD: begin
          remain_r <= remain_r - fill;
          state_r  <= S_MATCH;
        end
        S_REST: begin
          if (tif_r == lobm_pkg::TifIoc) begin
            st_r <= (remain_r == qty_r) ? lobm_pkg::StCantFill :
                    (remain_r != 32'd0) ? lobm_pkg::StPartial : lobm_pkg::StSuccess;
          end else if (tif_r == lobm_pkg::TifFok) begin
            st_r <= lobm_pkg::StSuccess;
          end else if (remain_r != 32'd0 && own_full) begin
            st_r <= lobm_pkg::StFull;
          end else begin
            st_r  <= (remain_r != 32'd0 && remain_r != qty_r) ?
                     lobm_pkg::StPartial : lobm_pkg::StSuccess;
            asg_r <= id_r;
          end
          state_r <= S_FIN;
        end
        S_SCAN: begin
          // bids then asks, best first
          if (scan_e.used && scan_e.id == target_r) begin
            st_r <= (mode_r == lobm_pkg::ModeModify &&
                     (qty_r == 32'd0 || qty_r > scan_e.amount)) ?
                    lobm_pkg::StBad : lobm_pkg::StSuccess;
            state_r <= S_EDIT;
          end else if (!scan_e.used || idx_r == (IW+1)'(BOOK_DEPTH - 1)) begin
            if (scan_side_r) begin
              st_r    <= lobm_pkg::StBad;
              state_r <= S_FIN;
            end else begin
              scan_side_r <= 1'b1;
              idx_r       <= '0;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EDIT: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            okind_r <= 1'b1;
            olast_r <= 1'b1;
            ob_r    <= '0;
            os_r    <= '0;
            op_r    <= '0;
            oa_r    <= '0;
            ost_r   <= st_r;
            oasg_r  <= asg_r;
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // market flag of the held request
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) market_r <= d[67];
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, oasg_r, ost_r, oa_r, op_r, os_r, ob_r};

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("idle with item pending");
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == out_tuser)) else $error("last/kind mismatch");
  a_trade_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[130:128] == 3'd0))
    else $error("trade with status");
  a_wait_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> (ov_r && olast_r)) else $error("wait without final");

endmodule
